FILE: rtl/ser_pkg.sv
`default_nettype none

package ser_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned DurWidth   = 16;
    localparam int unsigned ScaleWidth = 8;
    localparam int unsigned RangeWidth = DurWidth + ScaleWidth;
    localparam int unsigned AddrWidth  = 4;
    localparam int unsigned DataWidth  = 32;

    localparam logic [DurWidth-1:0]   TimeoutReset = 16'd30000;
    localparam logic [DurWidth-1:0]   MinDurReset  = 16'd115;
    localparam logic [DurWidth-1:0]   PeriodReset  = 16'd25000;
    localparam logic [ScaleWidth-1:0] ScaleReset   = 8'd170;

    localparam logic [1:0] RegTimeout = 2'd0;
    localparam logic [1:0] RegMinDur  = 2'd1;
    localparam logic [1:0] RegPeriod  = 2'd2;
    localparam logic [1:0] RegScale   = 2'd3;

    localparam logic [1:0] OpRise = 2'd0;
    localparam logic [1:0] OpFall = 2'd1;
    localparam logic [1:0] OpPoll = 2'd2;

    typedef struct packed {
        logic [DurWidth-1:0]   echo_limit;
        logic [DurWidth-1:0]   min_width;
        logic [DurWidth-1:0]   trigger_period_us;
        logic [ScaleWidth-1:0] um_per_us;
    } t_cfg;

    typedef struct packed {
        logic [RangeWidth-1:0] range_um;
        logic                  range_infinite;
        logic                  trigger_pulse;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ser_cfg.sv
`default_nettype none

module ser_cfg
    import ser_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [AddrWidth-1:0] paddr,
    input  wire logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0]      prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.echo_limit        <= TimeoutReset;
            r_cfg.min_width         <= MinDurReset;
            r_cfg.trigger_period_us <= PeriodReset;
            r_cfg.um_per_us         <= ScaleReset;
        end else if (wr_en) begin
            case (reg_idx)
                RegTimeout: r_cfg.echo_limit        <= pwdata[DurWidth-1:0];
                RegMinDur:  r_cfg.min_width         <= pwdata[DurWidth-1:0];
                RegPeriod:  r_cfg.trigger_period_us <= pwdata[DurWidth-1:0];
                RegScale:   r_cfg.um_per_us         <= pwdata[ScaleWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegTimeout: prdata = DataWidth'(r_cfg.echo_limit);
            RegMinDur:  prdata = DataWidth'(r_cfg.min_width);
            RegPeriod:  prdata = DataWidth'(r_cfg.trigger_period_us);
            RegScale:   prdata = DataWidth'(r_cfg.um_per_us);
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ser_core.sv
`default_nettype none

module ser_core
    import ser_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_upd,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [TimeWidth-1:0] i_now_us,
    input  wire t_cfg                 i_cfg,
    output t_result                   o_result
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [TimeWidth-1:0]  r_start, n_start;
    logic [TimeWidth-1:0]  r_last_trig, n_last_trig;
    logic [DurWidth-1:0]   r_dur, n_dur;
    logic                  r_fresh, n_fresh;
    logic [RangeWidth-1:0] r_held_range, n_held_range;
    logic                  r_held_inf, n_held_inf;

    logic [TimeWidth-1:0]  since_start;
    logic [TimeWidth-1:0]  since_trig;
    logic                  in_window;
    logic                  timed_out;
    logic [RangeWidth-1:0] product;
    logic                  pulse;

    assign since_start = i_now_us - r_start;
    assign since_trig  = i_now_us - r_last_trig;
    assign in_window   = (since_start >= TimeWidth'(i_cfg.min_width))
                      && (since_start <= TimeWidth'(i_cfg.echo_limit));
    assign timed_out   = (r_phase == PH_WAIT || r_phase == PH_TRIG)
                      && ((since_start > TimeWidth'(i_cfg.echo_limit))
                      ||  (since_trig  > TimeWidth'(i_cfg.echo_limit)));
    assign product     = RangeWidth'(r_dur) * RangeWidth'(i_cfg.um_per_us);

    always_comb begin
        n_phase      = r_phase;
        n_start      = r_start;
        n_last_trig  = r_last_trig;
        n_dur        = r_dur;
        n_fresh      = r_fresh;
        n_held_range = r_held_range;
        n_held_inf   = r_held_inf;
        pulse        = 1'b0;
        case (i_opcode)
            OpRise: begin
                if (r_phase == PH_IDLE || r_phase == PH_TRIG) begin
                    n_start = i_now_us;
                    n_phase = PH_WAIT;
                end
            end
            OpFall: begin
                if (r_phase == PH_WAIT) begin
                    n_dur   = in_window ? since_start[DurWidth-1:0] : '0;
                    n_fresh = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            OpPoll: begin
                if (timed_out) begin
                    n_held_inf   = 1'b1;
                    n_held_range = '0;
                    n_phase      = PH_IDLE;
                    n_fresh      = 1'b0;
                end
                if (r_fresh && !timed_out) begin
                    if (r_dur != '0) begin
                        n_held_range = product;
                        n_held_inf   = 1'b0;
                    end else begin
                        n_held_range = '0;
                        n_held_inf   = 1'b1;
                    end
                    n_fresh = 1'b0;
                end
                if (n_phase == PH_IDLE
                        && since_trig >= TimeWidth'(i_cfg.trigger_period_us)) begin
                    n_phase     = PH_TRIG;
                    n_last_trig = i_now_us;
                    n_start     = i_now_us;
                    pulse       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.range_um       = n_held_inf ? '0 : n_held_range;
    assign o_result.range_infinite = n_held_inf;
    assign o_result.trigger_pulse  = pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_start      <= '0;
            r_last_trig  <= '0;
            r_dur        <= '0;
            r_fresh      <= 1'b0;
            r_held_range <= '0;
            r_held_inf   <= 1'b0;
        end else if (i_upd) begin
            r_phase      <= n_phase;
            r_start      <= n_start;
            r_last_trig  <= n_last_trig;
            r_dur        <= n_dur;
            r_fresh      <= n_fresh;
            r_held_range <= n_held_range;
            r_held_inf   <= n_held_inf;
        end
    end

`ifndef SYNTHESIS
    a_pulse_enters_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd && pulse |=> r_phase == PH_TRIG && r_last_trig == r_start)
        else $error("trigger request did not arm the trigger phase");

    a_rise_starts_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd && i_opcode == OpRise && (r_phase == PH_IDLE || r_phase == PH_TRIG)
        |=> r_phase == PH_WAIT && r_start == $past(i_now_us))
        else $error("rising edge did not start the echo wait");

    a_inf_clears_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_inf |-> r_held_range == '0)
        else $error("infinite range holds a nonzero value");

    a_pulse_only_on_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd && i_opcode != OpPoll |=> r_last_trig == $past(r_last_trig))
        else $error("trigger time moved on an edge event");
`endif

endmodule

`default_nettype wire

FILE: rtl/sonar_echo_ranger.sv
`default_nettype none

// Ultrasonic time-of-flight ranging controller. Each request carries an event
// code (echo rising edge, echo falling edge, poll) and a 32-bit wrapping
// microsecond timestamp, and gives exactly one result: the held range in
// micrometres, an infinite flag and a trigger request that only a poll can
// raise. A request is registered at the input, processed against the ranging
// state and registered at the output, and one request is taken every cycle;
// the input stalls only while the output register holds a result that is
// itself stalled. The range is a single 16 x 8 bit multiply of the kept echo
// width by um_per_us. The four configuration registers sit on the APB port
// at byte offsets 0, 4, 8 and 12 and are meant to be written while no request
// is in flight.
module sonar_echo_ranger
    import ser_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [AddrWidth-1:0]  paddr,
    input  wire logic [DataWidth-1:0]  pwdata,
    output logic [DataWidth-1:0]       prdata,
    output logic                       pready,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [TimeWidth-1:0]  i_now_us,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [RangeWidth-1:0]      o_range_um,
    output logic                       o_range_infinite,
    output logic                       o_trigger_pulse
);

    t_cfg                 cfg;
    t_result              result;

    logic                 r_s1_valid;
    logic [1:0]           r_opcode;
    logic [TimeWidth-1:0] r_now_us;
    logic                 r_out_valid;
    t_result              r_result;

    logic                 s2_ready;
    logic                 advance;
    logic                 accept;

    assign s2_ready   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && s2_ready;
    assign o_in_stall = r_s1_valid && !s2_ready;
    assign accept     = i_in_valid && !o_in_stall;

    ser_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ser_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (advance),
        .i_opcode (r_opcode),
        .i_now_us (r_now_us),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode <= i_opcode;
            r_now_us <= i_now_us;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_range_um       = r_result.range_um;
    assign o_range_infinite = r_result.range_infinite;
    assign o_trigger_pulse  = r_result.trigger_pulse;

endmodule

`default_nettype wire

FILE: test/range_checker.sv
`timescale 1ns / 1ps

module range_checker
    import ser_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [AddrWidth-1:0]  i_paddr,
    input  logic [DataWidth-1:0]  i_pwdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_opcode,
    input  logic [TimeWidth-1:0]  i_now_us,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [RangeWidth-1:0] i_range_um,
    input  logic                  i_range_infinite,
    input  logic                  i_trigger_pulse,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef enum logic [1:0] {
        PhaseIdle      = 2'd0,
        PhaseTriggered = 2'd1,
        PhaseWaiting   = 2'd2
    } t_phase;

    t_cfg                  cfg;
    t_phase                phase;
    logic [TimeWidth-1:0]  echo_start;
    logic [TimeWidth-1:0]  last_trigger;
    logic [DurWidth-1:0]   kept_width;
    logic                  fresh;
    logic [RangeWidth-1:0] held_range;
    logic                  held_inf;
    t_result               expected_readings[$];
    int                    fails = 0;

    function automatic t_result predict_reading(input logic [1:0] op,
                                                input logic [TimeWidth-1:0] now);
        logic [TimeWidth-1:0] width;
        logic [TimeWidth-1:0] since_trigger;
        logic                 pulse;
        t_result              r;
        pulse = 1'b0;
        width = now - echo_start;
        since_trigger = now - last_trigger;
        case (op)
            OpRise: begin
                if (phase == PhaseIdle || phase == PhaseTriggered) begin
                    echo_start = now;
                    phase = PhaseWaiting;
                end
            end
            OpFall: begin
                if (phase == PhaseWaiting) begin
                    if (width >= TimeWidth'(cfg.min_width) &&
                        width <= TimeWidth'(cfg.echo_limit))
                        kept_width = width[DurWidth-1:0];
                    else
                        kept_width = '0;
                    fresh = 1'b1;
                    phase = PhaseIdle;
                end
            end
            OpPoll: begin
                if ((phase == PhaseWaiting || phase == PhaseTriggered) &&
                    (width > TimeWidth'(cfg.echo_limit) ||
                     since_trigger > TimeWidth'(cfg.echo_limit))) begin
                    held_inf = 1'b1;
                    held_range = '0;
                    phase = PhaseIdle;
                    fresh = 1'b0;
                end
                if (fresh) begin
                    if (kept_width != '0) begin
                        held_range = RangeWidth'(kept_width) * RangeWidth'(cfg.um_per_us);
                        held_inf = 1'b0;
                    end else begin
                        held_range = '0;
                        held_inf = 1'b1;
                    end
                    fresh = 1'b0;
                end
                if (phase == PhaseIdle &&
                    since_trigger >= TimeWidth'(cfg.trigger_period_us)) begin
                    phase = PhaseTriggered;
                    last_trigger = now;
                    echo_start = now;
                    pulse = 1'b1;
                end
            end
            default: ;
        endcase
        r.range_um = held_inf ? '0 : held_range;
        r.range_infinite = held_inf;
        r.trigger_pulse = pulse;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg = {TimeoutReset, MinDurReset, PeriodReset, ScaleReset};
            phase = PhaseIdle;
            echo_start = '0;
            last_trigger = '0;
            kept_width = '0;
            fresh = 1'b0;
            held_range = '0;
            held_inf = 1'b0;
            expected_readings.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    RegTimeout: cfg.echo_limit = i_pwdata[DurWidth-1:0];
                    RegMinDur:  cfg.min_width = i_pwdata[DurWidth-1:0];
                    RegPeriod:  cfg.trigger_period_us = i_pwdata[DurWidth-1:0];
                    RegScale:   cfg.um_per_us = i_pwdata[ScaleWidth-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_readings.push_back(predict_reading(i_opcode, i_now_us));
            if (i_out_valid && !i_out_stall) begin
                got = {i_range_um, i_range_infinite, i_trigger_pulse};
                if (expected_readings.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result: range %0d inf %0d trig %0d",
                                 got.range_um, got.range_infinite, got.trigger_pulse);
                    fails++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.range_um !== want.range_um ||
                        got.range_infinite !== want.range_infinite ||
                        got.trigger_pulse !== want.trigger_pulse) begin
                        if (fails < 10)
                            $display("mismatch at %0t: range %0d/%0d inf %0d/%0d trig %0d/%0d",
                                     $realtime, want.range_um, got.range_um,
                                     want.range_infinite, got.range_infinite,
                                     want.trigger_pulse, got.trigger_pulse);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_readings.size();
    end

endmodule

FILE: test/tb_sonar_echo_ranger.sv
`timescale 1ns / 1ps

module tb_sonar_echo_ranger;
    import ser_pkg::*;

    localparam int         WatchdogLimit = 2000;
    localparam int         HoldCycles    = 120;
    localparam logic [1:0] OpUnused      = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [AddrWidth-1:0]  paddr = '0;
    logic [DataWidth-1:0]  pwdata = '0;
    logic [DataWidth-1:0]  prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_opcode = OpPoll;
    logic [TimeWidth-1:0]  i_now_us = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [RangeWidth-1:0] o_range_um;
    logic                  o_range_infinite;
    logic                  o_trigger_pulse;

    int                    fail_count;
    int                    pending;
    logic                  quiet = 1'b0;
    logic                  hold_wanted = 1'b0;
    logic                  hold_taken = 1'b0;
    int                    hold_left = 0;
    int                    idle_cycles = 0;
    logic [DurWidth-1:0]   timeout_now = TimeoutReset;
    logic [DurWidth-1:0]   min_now = MinDurReset;
    logic [DurWidth-1:0]   period_now = PeriodReset;
    logic [TimeWidth-1:0]  clock_us = '0;
    int                    sent_items = 0;

    always #2 i_clk = ~i_clk;

    sonar_echo_ranger u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_now_us         (i_now_us),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_range_um       (o_range_um),
        .o_range_infinite (o_range_infinite),
        .o_trigger_pulse  (o_trigger_pulse)
    );

    range_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_now_us         (i_now_us),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_range_um       (o_range_um),
        .i_range_infinite (o_range_infinite),
        .i_trigger_pulse  (o_trigger_pulse),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // result side: random stalls, one long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_wanted && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HoldCycles;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 35);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("tb_sonar_echo_ranger NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apb_write(input logic [1:0] reg_idx, input logic [DataWidth-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_event(input logic [1:0] op, input logic [TimeWidth-1:0] t);
        while (!quiet && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_now_us <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ranging(input logic [DurWidth-1:0] to, input logic [DurWidth-1:0] mn,
                               input logic [DurWidth-1:0] per, input logic [ScaleWidth-1:0] sc);
        drain();
        apb_write(RegTimeout, {16'h0, to});
        apb_write(RegMinDur, {16'h0, mn});
        apb_write(RegPeriod, {16'h0, per});
        apb_write(RegScale, {24'h0, sc});
        timeout_now = to;
        min_now = mn;
        period_now = per;
    endtask

    // one trigger / echo / poll round, sometimes broken, sometimes noise
    task automatic echo_round();
        logic [TimeWidth-1:0] rise_t;
        logic [TimeWidth-1:0] width;
        int unsigned          pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            send_event(2'($urandom_range(3)),
                       ($urandom_range(1) != 0) ? $urandom() : clock_us + $urandom_range(50));
            return;
        end
        if ($urandom_range(9) == 0)
            clock_us = clock_us + $urandom_range(period_now);
        else
            clock_us = clock_us + TimeWidth'(period_now) + $urandom_range(3);
        send_event(OpPoll, clock_us);
        rise_t = clock_us + $urandom_range(timeout_now / 8);
        send_event(OpRise, rise_t);
        if ($urandom_range(9) == 0)
            send_event(OpRise, rise_t + $urandom_range(20));
        pick = $urandom_range(99);
        if (pick < 12) begin
            clock_us = rise_t + TimeWidth'(timeout_now) + 1 + $urandom_range(5);
            send_event(OpPoll, clock_us);
            return;
        end
        if (pick < 62)
            width = $urandom_range(min_now, timeout_now);
        else if (pick < 72)
            width = (min_now == 0) ? '0 : $urandom_range(min_now - 1);
        else if (pick < 82)
            width = TimeWidth'(timeout_now) + 1 + $urandom_range(100);
        else if (pick < 91)
            width = ($urandom_range(1) != 0) ? TimeWidth'(min_now) : TimeWidth'(timeout_now);
        else
            width = $urandom_range(3);
        clock_us = rise_t + width;
        send_event(OpFall, clock_us);
        if ($urandom_range(9) == 0)
            send_event(OpFall, clock_us + 1);
        clock_us = clock_us + $urandom_range(3);
        send_event(OpPoll, clock_us);
    endtask

    task automatic run_phase(input logic [DurWidth-1:0] to, input logic [DurWidth-1:0] mn,
                             input logic [DurWidth-1:0] per, input logic [ScaleWidth-1:0] sc,
                             input int count);
        int target;
        set_ranging(to, mn, per, sc);
        target = sent_items + count;
        while (sent_items < target) echo_round();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register reset values
        send_event(OpPoll, 32'd0);
        send_event(OpFall, 32'd10);
        send_event(OpPoll, 32'd25000);
        send_event(OpRise, 32'd25100);
        send_event(OpRise, 32'd25300);
        send_event(OpFall, 32'd25215);
        send_event(OpPoll, 32'd25220);
        send_event(OpUnused, 32'hFFFF_FFFF);
        send_event(OpRise, 32'd60000);
        send_event(OpFall, 32'd90000);
        send_event(OpPoll, 32'd90001);
        send_event(OpRise, 32'd90010);
        send_event(OpFall, 32'd120011);
        send_event(OpPoll, 32'd120012);
        send_event(OpRise, 32'd120100);
        send_event(OpFall, 32'd120214);
        send_event(OpPoll, 32'd120300);
        send_event(OpPoll, 32'd150000);
        send_event(OpPoll, 32'd180001);
        send_event(OpPoll, 32'hFFFF_FFF0);

        // widest window, largest scale, wrapping timestamps, zero width
        set_ranging(16'hFFFF, 16'd0, 16'd0, 8'hFF);
        send_event(OpRise, 32'hFFFF_FFF8);
        send_event(OpFall, 32'h0000_FFF7);
        send_event(OpPoll, 32'h0001_0000);
        send_event(OpRise, 32'd5);
        send_event(OpFall, 32'd5);
        send_event(OpPoll, 32'd6);

        clock_us = $urandom();
        quiet <= 1'b1;
        run_phase(16'd400, 16'd20, 16'd300, 8'($urandom_range(1, 255)), 180);
        quiet <= 1'b0;
        run_phase(TimeoutReset, MinDurReset, PeriodReset, ScaleReset, 20);
        hold_wanted <= 1'b1;
        run_phase(16'd300, 16'd10, 16'd200, 8'd170, 160);
        clock_us = 32'hFFFF_0000;
        run_phase(16'hFFFF, 16'd0, 16'd0, 8'hFF, 150);
        run_phase(16'd1, 16'd0, 16'hFFFF, 8'd1, 100);
        run_phase(16'd0, 16'd0, 16'd0, 8'd0, 60);
        run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 8'($urandom_range(255)), 230);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_sonar_echo_ranger OK");
        end else begin
            $display("tb_sonar_echo_ranger NOT OK");
        end
        $finish;
    end

endmodule
